// File: rtl/core/waw_pkg.sv
// Shared types and constants for the weekly alarm table matcher.
package waw_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  index;
        logic [6:0]  day_mask;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic        enable;
        logic        recurring;
        logic [11:0] action_code;
        logic [2:0]  now_weekday;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [3:0]  entry;
        logic [6:0]  out_day_mask;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic        out_enable;
        logic        out_recurring;
        logic [11:0] out_action;
        logic [4:0]  entries_used;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  mask;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        active;
        logic        repeat_en;
        logic [11:0] action;
    } t_entry;

endpackage

// File: rtl/core/waw_cell.sv
// One table cell: holds one alarm entry and passes it to its neighbor on shift.
module waw_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  waw_pkg::t_entry i_entry,
    output waw_pkg::t_entry o_entry
);

    waw_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/core/weekly_alarm_table_matcher.sv
// Top level: weekly alarm table held in a rotating ring of cells, plus its sequencer.
//
// Usage: drive i_item and raise i_start; the item is taken at a clock edge where
// i_start is high and o_busy is low. Results appear on o_result for one cycle,
// marked by o_strobe; the receiver cannot stall them, so it must take each one.
// Add, update and read give exactly one result, tick gives one per fired alarm
// (none if nothing fires or the minute equals the last checked one), with last
// set on the final result of the item.
// Ring: the table is a ring of TABLE_DEPTH cells that rotates one position per
// cycle while an item is serviced; every serviced item rotates it exactly once
// round; o_busy covers that turn, plus the flush state when a tick fired anything.
// Rejected requests (table full, bad index) and ticks on an already checked
// minute answer from the accept cycle without going busy.
// Replies: a reply is registered and comes out in the cycle after the ring brings
// the target entry to the head. The last fired alarm of a tick is held back until
// the rotation ends so its last bit is right.
// Reset (synchronous, active low) empties the table and forgets the checked
// minute; the cell contents themselves are not cleared and are never read
// before being written.
module weekly_alarm_table_matcher #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  waw_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output waw_pkg::t_out_item o_result
);

    localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > 4) ? CW : 4;
    localparam int MW = $clog2(waw_pkg::MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_pos, n_pos;
    logic [PW-1:0]      r_tgt, n_tgt;
    logic [CW-1:0]      r_used, n_used;
    logic [5:0]         r_chk_min, n_chk_min;
    logic               r_chk_vld, n_chk_vld;
    logic [MW-1:0]      r_cnt, n_cnt;
    logic               r_pend, n_pend;
    waw_pkg::t_out_item r_pend_item, n_pend_item;
    waw_pkg::t_in_item  r_cmd, n_cmd;
    logic               r_stb, n_stb;
    waw_pkg::t_out_item r_out, n_out;

    waw_pkg::t_entry    w_ring [TABLE_DEPTH];
    waw_pkg::t_entry    w_wb;
    waw_pkg::t_entry    w_load;
    logic               w_shift;

    assign w_shift = (r_state == ST_RUN);

    // ring: cell 0 is the head; the written-back head value re-enters at the tail
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        waw_pkg::t_entry w_in;
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_in = w_wb;
        end else begin : g_mid
            assign w_in = w_ring[g+1];
        end
        waw_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_entry (w_in),
            .o_entry (w_ring[g])
        );
    end

    assign w_load = '{mask: r_cmd.day_mask, hour: r_cmd.alarm_hour,
                      minute: r_cmd.alarm_minute, active: r_cmd.enable,
                      repeat_en: r_cmd.recurring, action: r_cmd.action_code};

    function automatic waw_pkg::t_out_item make_out(
        input logic            kind,
        input logic [3:0]      entry,
        input waw_pkg::t_entry e,
        input logic [4:0]      used,
        input logic            last
    );
        waw_pkg::t_out_item o;
        o.kind          = kind;
        o.ok            = 1'b1;
        o.entry         = entry;
        o.out_day_mask  = e.mask;
        o.out_hour      = e.hour;
        o.out_minute    = e.minute;
        o.out_enable    = e.active;
        o.out_recurring = e.repeat_en;
        o.out_action    = e.action;
        o.entries_used  = used;
        o.last          = last;
        return o;
    endfunction

    always_comb begin
        waw_pkg::t_out_item fail;
        waw_pkg::t_entry    head;
        logic               hit;
        logic               at_tgt;
        logic [3:0]         pos4;
        logic [4:0]         used5;

        n_state     = r_state;
        n_pos       = r_pos;
        n_tgt       = r_tgt;
        n_used      = r_used;
        n_chk_min   = r_chk_min;
        n_chk_vld   = r_chk_vld;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_item = r_pend_item;
        n_cmd       = r_cmd;
        n_stb       = 1'b0;
        n_out       = r_out;

        used5 = 5'(XW'(r_used));
        fail  = '0;
        fail.kind         = waw_pkg::KIND_REPLY;
        fail.entries_used = used5;
        fail.last         = 1'b1;

        head   = w_ring[0];
        w_wb   = head;
        at_tgt = (r_pos == r_tgt);
        pos4   = 4'(XW'(r_pos));
        hit    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd = i_item;
                    n_pos = '0;
                    n_cnt = '0;
                    case (i_item.opcode)
                        waw_pkg::OP_ADD: begin
                            if (XW'(r_used) >= XW'(TABLE_DEPTH)) begin
                                n_stb = 1'b1;
                                n_out = fail;
                            end else begin
                                n_tgt   = PW'(r_used);
                                n_used  = r_used + CW'(1);
                                n_state = ST_RUN;
                            end
                        end
                        waw_pkg::OP_UPDATE, waw_pkg::OP_READ: begin
                            if (XW'(i_item.index) >= XW'(r_used) ||
                                XW'(i_item.index) >= XW'(TABLE_DEPTH)) begin
                                n_stb = 1'b1;
                                n_out = fail;
                            end else begin
                                n_tgt   = PW'(i_item.index);
                                n_state = ST_RUN;
                            end
                        end
                        default: begin
                            if (!(r_chk_vld && r_chk_min == i_item.now_minute)) begin
                                n_chk_min = i_item.now_minute;
                                n_chk_vld = 1'b1;
                                n_state   = ST_RUN;
                            end
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_pos = r_pos + PW'(1);
                case (r_cmd.opcode)
                    waw_pkg::OP_ADD, waw_pkg::OP_UPDATE: begin
                        if (at_tgt) begin
                            w_wb  = w_load;
                            n_stb = 1'b1;
                            n_out = make_out(waw_pkg::KIND_REPLY, pos4, w_load, used5, 1'b1);
                        end
                    end
                    waw_pkg::OP_READ: begin
                        if (at_tgt) begin
                            n_stb = 1'b1;
                            n_out = make_out(waw_pkg::KIND_REPLY, pos4, head, used5, 1'b1);
                        end
                    end
                    default: begin
                        hit = (XW'(r_pos) < XW'(r_used)) && head.active &&
                              (r_cmd.now_weekday != 3'd0) &&
                              head.mask[3'(r_cmd.now_weekday - 3'd1)] &&
                              (head.minute == r_cmd.now_minute) &&
                              (head.hour == r_cmd.now_hour) &&
                              (r_cnt < MW'(waw_pkg::MAX_RESULTS));
                        if (hit) begin
                            if (!head.repeat_en) begin
                                w_wb.active = 1'b0;
                            end
                            // the previous hit is now known not to be the last
                            if (r_pend) begin
                                n_stb = 1'b1;
                                n_out = r_pend_item;
                            end
                            n_pend      = 1'b1;
                            n_pend_item = make_out(waw_pkg::KIND_FIRE, pos4, w_wb, used5, 1'b0);
                            n_cnt       = r_cnt + MW'(1);
                        end
                    end
                endcase
                if (XW'(r_pos) == XW'(TABLE_DEPTH - 1)) begin
                    n_pos   = '0;
                    n_state = (hit || r_pend) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                n_stb      = 1'b1;
                n_out      = r_pend_item;
                n_out.last = 1'b1;
                n_pend     = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_used    <= '0;
            r_chk_min <= '0;
            r_chk_vld <= 1'b0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_stb     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_used    <= n_used;
            r_chk_min <= n_chk_min;
            r_chk_vld <= n_chk_vld;
            r_cnt     <= n_cnt;
            r_pend    <= n_pend;
            r_stb     <= n_stb;
        end
        r_tgt       <= n_tgt;
        r_cmd       <= n_cmd;
        r_pend_item <= n_pend_item;
        r_out       <= n_out;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_out;

    // replies always close their item
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stb && r_out.kind == waw_pkg::KIND_REPLY) |-> r_out.last)
        else $error("reply without last");

    // a rejected reply carries no entry
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stb && !r_out.ok) |-> (r_out.entry == 4'd0 && r_out.out_action == 12'd0))
        else $error("rejected reply carries data");

    // nothing is pending between items
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("pending alarm left at idle");

    // table never overfills
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_used) <= XW'(TABLE_DEPTH))
        else $error("entry count overflow");

    // the ring is back at alignment whenever a new item can be taken
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pos == '0))
        else $error("ring misaligned at idle");

endmodule

// File: tb/weekly_alarm_table_checker.sv
// Checker: watches the item and result channels, predicts alarm table results, compares.
module weekly_alarm_table_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  waw_pkg::t_in_item  i_item,
    input  logic               i_strobe,
    input  waw_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_fired_count
);

    waw_pkg::t_entry    alarm_table [16];
    int                 entry_count;
    logic [5:0]         last_minute;
    logic               minute_seen;
    waw_pkg::t_out_item expected_results [$];

    initial begin
        o_fail_count  = 0;
        o_fired_count = 0;
    end

    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what, input waw_pkg::t_out_item got,
                                   input waw_pkg::t_out_item want);
        $display("mismatch %s at %0t: got %h want %h", what, $time, got, want);
        o_fail_count++;
    endtask

    function automatic waw_pkg::t_out_item make_result(logic kind, logic ok, int idx,
                                                       waw_pkg::t_entry e, logic is_last);
        waw_pkg::t_out_item r;
        r.kind          = kind;
        r.ok            = ok;
        r.entry         = idx[3:0];
        r.out_day_mask  = e.mask;
        r.out_hour      = e.hour;
        r.out_minute    = e.minute;
        r.out_enable    = e.active;
        r.out_recurring = e.repeat_en;
        r.out_action    = e.action;
        r.entries_used  = entry_count[4:0];
        r.last          = is_last;
        return r;
    endfunction

    function automatic waw_pkg::t_entry entry_from_item(waw_pkg::t_in_item it);
        waw_pkg::t_entry e;
        e.mask      = it.day_mask;
        e.hour      = it.alarm_hour;
        e.minute    = it.alarm_minute;
        e.active    = it.enable;
        e.repeat_en = it.recurring;
        e.action    = it.action_code;
        return e;
    endfunction

    // Applies one accepted item to the table copy and queues its results.
    task automatic predict_alarm_item(input waw_pkg::t_in_item it);
        waw_pkg::t_entry blank;
        int              hits;
        logic            day_hit;
        blank = '0;
        hits  = 0;
        case (it.opcode)
            waw_pkg::OP_ADD: begin
                if (entry_count >= 16) begin
                    expected_results.push_back(make_result(waw_pkg::KIND_REPLY, 1'b0, 0,
                        blank, 1'b1));
                end else begin
                    alarm_table[entry_count] = entry_from_item(it);
                    entry_count++;
                    expected_results.push_back(make_result(waw_pkg::KIND_REPLY, 1'b1,
                        entry_count - 1, alarm_table[entry_count - 1], 1'b1));
                end
            end
            waw_pkg::OP_UPDATE, waw_pkg::OP_READ: begin
                if (int'(it.index) >= entry_count) begin
                    expected_results.push_back(make_result(waw_pkg::KIND_REPLY, 1'b0, 0,
                        blank, 1'b1));
                end else begin
                    if (it.opcode == waw_pkg::OP_UPDATE)
                        alarm_table[it.index] = entry_from_item(it);
                    expected_results.push_back(make_result(waw_pkg::KIND_REPLY, 1'b1,
                        int'(it.index), alarm_table[it.index], 1'b1));
                end
            end
            default: begin
                if (!(minute_seen && last_minute == it.now_minute)) begin
                    last_minute = it.now_minute;
                    minute_seen = 1'b1;
                    for (int i = 0; i < entry_count && hits < waw_pkg::MAX_RESULTS; i++) begin
                        day_hit = it.now_weekday != 0 &&
                                  alarm_table[i].mask[it.now_weekday - 1];
                        if (alarm_table[i].active && day_hit &&
                            alarm_table[i].minute == it.now_minute &&
                            alarm_table[i].hour == it.now_hour) begin
                            if (!alarm_table[i].repeat_en) alarm_table[i].active = 1'b0;
                            expected_results.push_back(make_result(waw_pkg::KIND_FIRE, 1'b1,
                                i, alarm_table[i], 1'b0));
                            hits++;
                        end
                    end
                    if (hits > 0) expected_results[$].last = 1'b1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = 0;
            last_minute = '0;
            minute_seen = 1'b0;
            expected_results.delete();
        end else begin
            // result first: a reply can never come out in its own accept cycle
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", i_result, '0);
                end else begin
                    if (i_result !== expected_results[0])
                        report_mismatch("result fields", i_result, expected_results[0]);
                    if (i_result.kind == waw_pkg::KIND_FIRE) o_fired_count++;
                    void'(expected_results.pop_front());
                end
            end
            if (i_start && !i_busy) predict_alarm_item(i_item);
        end
    end

endmodule

// File: tb/tb_weekly_alarm_table_matcher.sv
// Testbench top: drives alarm table commands and ticks, gives the verdict.
module tb_weekly_alarm_table_matcher;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    waw_pkg::t_in_item  item = '0;
    logic               busy, strobe;
    waw_pkg::t_out_item result;
    int                 fail_count, pending, fired_count;
    int                 cycle_count = 0;
    int                 items_sent = 0;
    // Alarm times reused by ticks so matches actually happen.
    logic [4:0] hot_hour [4];
    logic [5:0] hot_minute [4];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    weekly_alarm_table_matcher DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_start (start),
        .i_item  (item),
        .o_busy  (busy),
        .o_strobe(strobe),
        .o_result(result)
    );

    weekly_alarm_table_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_fired_count(fired_count)
    );

    // Generous limit: every item at full scan plus gaps, many times over.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_weekly_alarm_table_matcher: FAIL");
            $finish;
        end
    end

    // Present one item after a random gap, hold until the block takes it.
    // Start stays up at the final negedge; the next call either drives a new
    // item right away or drops start for its gap.
    task automatic send_item(input waw_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic waw_pkg::t_in_item random_item();
        waw_pkg::t_in_item it;
        logic [63:0]       raw;
        raw = {$urandom, $urandom};
        it  = raw[$bits(waw_pkg::t_in_item)-1:0];
        return it;
    endfunction

    // Well-formed entry, usually aimed at one of the hot times.
    function automatic waw_pkg::t_in_item entry_item(logic [1:0] op, logic [3:0] idx);
        waw_pkg::t_in_item it;
        int                h;
        it = random_item();
        h  = $urandom_range(0, 3);
        it.opcode = op;
        it.index  = idx;
        if ($urandom_range(0, 3) != 0) begin
            it.alarm_hour   = hot_hour[h];
            it.alarm_minute = hot_minute[h];
            it.enable       = ($urandom_range(0, 4) != 0);
        end
        return it;
    endfunction

    function automatic waw_pkg::t_in_item tick_item(logic [2:0] wd, logic [4:0] hr,
                                                    logic [5:0] mn);
        waw_pkg::t_in_item it;
        it = random_item();
        it.opcode      = waw_pkg::OP_TICK;
        it.now_weekday = wd;
        it.now_hour    = hr;
        it.now_minute  = mn;
        return it;
    endfunction

    // Wait for the block to settle and all expected results to arrive before the verdict.
    task automatic drain();
        while (pending != 0 || busy) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial begin
        waw_pkg::t_in_item it;
        int                h;
        for (int k = 0; k < 4; k++) begin
            hot_hour[k]   = 5'($urandom_range(0, 23));
            hot_minute[k] = 6'($urandom_range(0, 59));
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: failed read/update on an empty table, tick with nothing.
        it = entry_item(waw_pkg::OP_READ, 4'd0);        send_item(it);
        it = entry_item(waw_pkg::OP_UPDATE, 4'd15);     send_item(it);
        it = tick_item(3'd1, 5'd0, 6'd0);               send_item(it);
        // Extremes of every entry field, both repeat kinds.
        it = entry_item(waw_pkg::OP_ADD, 4'd0);
        it.day_mask = 7'h7f; it.alarm_hour = 5'd31; it.alarm_minute = 6'd63;
        it.enable = 1'b1; it.recurring = 1'b1; it.action_code = 12'hfff;
        send_item(it);
        it = entry_item(waw_pkg::OP_ADD, 4'd0);
        it.day_mask = 7'h00; it.alarm_hour = 5'd0; it.alarm_minute = 6'd0;
        it.enable = 1'b0; it.recurring = 1'b0; it.action_code = 12'h000;
        send_item(it);
        // Fill to full with all-days alarms at hour 5 minute 7, alternately one-shot and repeating.
        for (int k = 2; k < 16; k++) begin
            it = entry_item(waw_pkg::OP_ADD, 4'd0);
            it.day_mask = 7'h7f; it.alarm_hour = 5'd5; it.alarm_minute = 6'd7;
            it.enable = 1'b1; it.recurring = 1'(k % 2);
            send_item(it);
        end
        it = entry_item(waw_pkg::OP_ADD, 4'd0);          send_item(it);  // table full
        // Out-of-use tick values: hour 31 minute 63, then the same minute again.
        it = tick_item(3'd7, 5'd31, 6'd63);     send_item(it);
        it = tick_item(3'd7, 5'd31, 6'd63);     send_item(it);
        it = tick_item(3'd0, 5'd5, 6'd7);       send_item(it);  // weekday zero
        it = tick_item(3'd1, 5'd5, 6'd8);       send_item(it);  // no match
        it = tick_item(3'd3, 5'd5, 6'd7);       send_item(it);  // many matches
        it = tick_item(3'd3, 5'd5, 6'd9);       send_item(it);
        it = tick_item(3'd3, 5'd5, 6'd7);       send_item(it);  // one-shots now cleared
        it = entry_item(waw_pkg::OP_READ, 4'd15);        send_item(it);
        it = entry_item(waw_pkg::OP_UPDATE, 4'd1);       send_item(it);

        // Random: cycles of clear-ish table use with matching ticks. Reset is not
        // reissued, so the table stays full and updates keep contents moving.
        while (items_sent < 210) begin
            h = $urandom_range(0, 9);
            if (h < 4) begin
                it = entry_item(waw_pkg::OP_UPDATE, 4'($urandom_range(0, 15)));
            end else if (h < 5) begin
                it = entry_item(waw_pkg::OP_READ, 4'($urandom_range(0, 15)));
            end else if (h < 6) begin
                it = random_item();
            end else begin
                int k;
                k = $urandom_range(0, 3);
                it = tick_item(3'($urandom_range(0, 7)), hot_hour[k], hot_minute[k]);
                if ($urandom_range(0, 5) == 0) it.now_minute = 6'($urandom_range(0, 63));
            end
            send_item(it);
        end
        start <= 1'b0;

        drain();
        $display("covered %0d items: full table, bad indexes, repeat and one-shot firing",
                 items_sent);
        $display("alarm results fired: %0d", fired_count);
        if (fail_count == 0) begin
            $display("tb_weekly_alarm_table_matcher: PASS");
        end else begin
            $display("tb_weekly_alarm_table_matcher: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/waw_pkg.sv
rtl/core/waw_cell.sv
rtl/core/weekly_alarm_table_matcher.sv
tb/weekly_alarm_table_checker.sv
tb/tb_weekly_alarm_table_matcher.sv
